[design/sle_pkg.sv]
// Shared types and codes of the sorted list engine.
package sle_pkg;

   localparam int VALUE_W = 32;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_SEARCH = 3'd2;
   localparam logic [2:0] CMD_LIST   = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [2:0] OP_HOLD    = 3'd0;
   localparam logic [2:0] OP_COMPARE = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_REMOVE  = 3'd3;
   localparam logic [2:0] OP_ROTATE  = 3'd4;

   typedef struct packed {
      logic [2:0]                op;
      logic signed [VALUE_W-1:0] operand;
   } sle_ctl_type;

endpackage

[design/sorted_list_engine.sv]
// Top level of the sorted list engine: command sequencer, cell chain and result register.
// Values sit in ascending signed order in a chain of CAPACITY cells; the store is empty
// after reset. Insert, delete and search compare every cell's entry with the operand on
// acceptance; then, once the output register is free, the chain shifts by one place for
// an insert into a non-full store or a found delete, and the single result item is loaded
// into the output register. List and clear also compare first; on a non-empty store they
// set up the stream, then stream one entry per cycle while the consumer does not stall,
// from the head of the chain, which rotates through the occupied cells. An unused command
// code is accepted and dropped. Results are held in an output register while the consumer
// stalls; the next item is accepted once the current one has produced all its results.
module sorted_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic signed [sle_pkg::VALUE_W-1:0] req_tdata,  // value
   input  logic [2:0]                         req_tuser,  // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic signed [sle_pkg::VALUE_W-1:0] rsp_tdata,  // item_value
   output logic [1:0]                         rsp_tuser,  // status
   output logic                               rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   remain_ff, remain_in;
   logic [2:0]                         cmd_ff;
   logic signed [sle_pkg::VALUE_W-1:0] value_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [sle_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               load;
   logic                               accept;
   logic                               out_free;
   logic                               found;
   sle_pkg::sle_ctl_type               ctl;

   logic signed [sle_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]                cell_gt;
   logic [CAPACITY-1:0]                cell_after;
   logic [CAPACITY-1:0]                cell_eq;
   logic [CAPACITY-1:0]                occupied;
   logic [CAPACITY-1:0]                tail;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign found      = |cell_eq;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic                               left_gt;
         logic                               left_after;
         logic signed [sle_pkg::VALUE_W-1:0] left_value;
         logic signed [sle_pkg::VALUE_W-1:0] right_value;

         assign occupied[g] = (CNT_W'(g) < count_ff);
         assign tail[g]     = (CNT_W'(g + 1) == count_ff);

         if (g == 0) begin : g_first
            assign left_gt    = 1'b0;
            assign left_after = 1'b0;
            assign left_value = cell_value[g];
         end else begin : g_inner
            assign left_gt    = cell_gt[g-1];
            assign left_after = cell_after[g-1];
            assign left_value = cell_value[g-1];
         end

         if (g == CAPACITY - 1) begin : g_end
            assign right_value = cell_value[g];
         end else begin : g_mid
            assign right_value = cell_value[g+1];
         end

         sle_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[g]),
            .tail        (tail[g]),
            .left_gt     (left_gt),
            .left_after  (left_after),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .value       (cell_value[g]),
            .gt          (cell_gt[g]),
            .after       (cell_after[g]),
            .eq          (cell_eq[g])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      load          = 1'b0;
      rsp_value_in  = value_ff;
      rsp_status_in = sle_pkg::ST_OK;
      rsp_last_in   = 1'b1;
      ctl.op        = sle_pkg::OP_HOLD;
      ctl.operand   = (state_ff == S_IDLE) ? req_tdata : value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser <= sle_pkg::CMD_CLEAR)) begin
               ctl.op   = sle_pkg::OP_COMPARE;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               load     = 1'b1;
               if (cmd_ff == sle_pkg::CMD_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = sle_pkg::ST_FULL;
                  end else begin
                     ctl.op   = sle_pkg::OP_INSERT;
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = sle_pkg::ST_EMPTY;
               end else begin
                  case (cmd_ff) inside
                     sle_pkg::CMD_DELETE, sle_pkg::CMD_SEARCH: begin
                        if (!found) begin
                           rsp_status_in = sle_pkg::ST_NOT_FOUND;
                        end else if (cmd_ff == sle_pkg::CMD_DELETE) begin
                           ctl.op   = sle_pkg::OP_REMOVE;
                           count_in = count_ff - 1'b1;
                        end
                     end
                     default: begin
                        load      = 1'b0;
                        remain_in = count_ff;
                        state_in  = S_STREAM;
                     end
                  endcase
               end
            end
         end
         S_STREAM: begin
            if (out_free) begin
               load         = 1'b1;
               ctl.op       = sle_pkg::OP_ROTATE;
               rsp_value_in = cell_value[0];
               rsp_last_in  = (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
                  if (cmd_ff == sle_pkg::CMD_CLEAR) begin
                     count_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser;
         value_ff <= req_tdata;
      end
      if (load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_stream_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STREAM |-> remain_ff != '0)
      else $error("Streaming with no entries left.");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && out_free && cmd_ff == sle_pkg::CMD_INSERT &&
       count_ff == CNT_W'(CAPACITY)) |=> $stable(count_ff))
      else $error("Insert into a full store changed the count.");
`endif

endmodule

[design/sle_cell.sv]
// One cell of the sorted chain: holds one entry and its compare flags.
module sle_cell (
   input  logic                               clock,
   input  sle_pkg::sle_ctl_type               ctl,
   input  logic                               occupied,
   input  logic                               tail,
   input  logic                               left_gt,
   input  logic                               left_after,
   input  logic signed [sle_pkg::VALUE_W-1:0] left_value,
   input  logic signed [sle_pkg::VALUE_W-1:0] right_value,
   input  logic signed [sle_pkg::VALUE_W-1:0] head_value,
   output logic signed [sle_pkg::VALUE_W-1:0] value,
   output logic                               gt,
   output logic                               after,
   output logic                               eq
);

   logic signed [sle_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               gt_ff, gt_in;
   logic                               ge_ff, ge_in;
   logic                               eq_ff, eq_in;
   logic                               after_pt;

   assign after_pt = gt_ff || !occupied;

   always_comb begin
      value_in = value_ff;
      gt_in    = gt_ff;
      ge_in    = ge_ff;
      eq_in    = eq_ff;
      unique case (ctl.op)
         sle_pkg::OP_HOLD: begin
         end
         sle_pkg::OP_COMPARE: begin
            gt_in = occupied && (value_ff > ctl.operand);
            ge_in = occupied && (value_ff >= ctl.operand);
            eq_in = occupied && (value_ff == ctl.operand);
         end
         sle_pkg::OP_INSERT: begin
            if (left_gt) begin
               value_in = left_value;
            end else if (after_pt && !left_after) begin
               value_in = ctl.operand;
            end
         end
         sle_pkg::OP_REMOVE: begin
            if (ge_ff) begin
               value_in = right_value;
            end
         end
         sle_pkg::OP_ROTATE: begin
            value_in = tail ? head_value : right_value;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      gt_ff    <= gt_in;
      ge_ff    <= ge_in;
      eq_ff    <= eq_in;
   end

   assign value = value_ff;
   assign gt    = gt_ff;
   assign after = after_pt;
   assign eq    = eq_ff;

endmodule
